FILE: hdl/cfrf_pkg.sv
// shared types and constants of the frame rate filter
package cfrf_pkg;

   localparam int unsigned ID_WIDTH = 29;
   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned MED_SLOTS = 3;
   localparam int unsigned MED_SLOT_WIDTH = 2;
   localparam int unsigned BYTE_VALUES = 256;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_WIDTH = 1;
   localparam int unsigned QUEUE_CNT_WIDTH = 2;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [ID_WIDTH-1:0] CRIT_ID_FIRST = 29'h100;
   localparam logic [ID_WIDTH-1:0] CRIT_ID_LAST = 29'h103;
   localparam logic [ID_WIDTH-1:0] MED_ID_FIRST = 29'h104;
   localparam logic [ID_WIDTH-1:0] MED_ID_LAST = 29'h106;

   localparam logic [TIME_WIDTH-1:0] MED_INTERVAL_RESET = 32'd1000;
   localparam logic [TIME_WIDTH-1:0] LOW_INTERVAL_RESET = 32'd5000;

   localparam logic CSR_MED_INTERVAL = 1'b0;
   localparam logic CSR_LOW_INTERVAL = 1'b1;

   typedef enum logic [1:0] {
      PRIO_CRITICAL = 2'd0,
      PRIO_MEDIUM = 2'd1,
      PRIO_LOW = 2'd2
   } prio_class_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] can_id;
      logic [TIME_WIDTH-1:0] now_ms;
   } req_beat_type;

   typedef struct packed {
      logic pass_frame;
      logic [1:0] priority_class;
   } rsp_beat_type;

   typedef struct packed {
      prio_class_type prio;
      logic [MED_SLOT_WIDTH-1:0] med_slot;
      logic [TIME_WIDTH-1:0] now_ms;
   } work_item_type;

endpackage

FILE: hdl/can_frame_rate_filter_unit.sv
// top level of the per-identifier frame rate filter
//
// req channel: one beat per received frame (can_id, now_ms), valid/ready.
// rsp channel: one beat per request (pass_frame, priority_class), in order.
// csr port: APB-style; 0x0 medium interval, 0x4 low interval (ms), pready
// always high, writes land on the access cycle, reads return the value.
// Identifiers 0x100-0x103 always pass, 0x104-0x106 each keep a last-pass
// time, all others share a last-pass time per bucket of the low byte.
// Path: a request beat is written into the front queue, then read into the
// store read stage, then registered as the response beat in the result register.
// Throughput: one beat per cycle while rsp_ready is high; the low bucket store is
// one read and one write port, with the write of one beat forwarded to the next's read.
// Reset: intervals return to 1000 and 5000 ms, all last-pass times read as
// zero at once (per-bucket valid flags), no clearing pass.
// rsp stall: the result register holds, the store stage holds behind it,
// and the two-entry queue takes up to two more beats before req_ready drops.
module can_frame_rate_filter_unit #(
   parameter int unsigned LOW_BUCKETS = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  cfrf_pkg::req_beat_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output cfrf_pkg::rsp_beat_type                 rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [cfrf_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [cfrf_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [cfrf_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                   pready
);

   localparam int unsigned USED_BUCKETS =
      (LOW_BUCKETS < cfrf_pkg::BYTE_VALUES) ? LOW_BUCKETS : cfrf_pkg::BYTE_VALUES;
   localparam int unsigned BUCKET_WIDTH = $clog2(USED_BUCKETS);
   localparam int unsigned ENTRY_WIDTH = $bits(cfrf_pkg::work_item_type) + BUCKET_WIDTH;

   logic [cfrf_pkg::TIME_WIDTH-1:0] med_interval_ff, med_interval_in;
   logic [cfrf_pkg::TIME_WIDTH-1:0] low_interval_ff, low_interval_in;
   logic csr_write;

   cfrf_pkg::work_item_type front_item, q_item;
   logic [BUCKET_WIDTH-1:0] front_bucket, q_bucket;
   logic q_full, q_empty, q_pop, q_push;
   logic [ENTRY_WIDTH-1:0] q_push_data, q_pop_data;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      med_interval_in = med_interval_ff;
      low_interval_in = low_interval_ff;
      if (csr_write) begin
         unique case (paddr[2])
            cfrf_pkg::CSR_MED_INTERVAL: med_interval_in = pwdata;
            cfrf_pkg::CSR_LOW_INTERVAL: low_interval_in = pwdata;
            default: ;
         endcase
      end
      unique case (paddr[2])
         cfrf_pkg::CSR_MED_INTERVAL: prdata = med_interval_ff;
         cfrf_pkg::CSR_LOW_INTERVAL: prdata = low_interval_ff;
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         med_interval_ff <= cfrf_pkg::MED_INTERVAL_RESET;
         low_interval_ff <= cfrf_pkg::LOW_INTERVAL_RESET;
      end else begin
         med_interval_ff <= med_interval_in;
         low_interval_ff <= low_interval_in;
      end
   end

   cfrf_front #(
      .LOW_BUCKETS  (LOW_BUCKETS),
      .BUCKET_WIDTH (BUCKET_WIDTH)
   ) u_front (
      .req_beat (req_data),
      .item     (front_item),
      .bucket   (front_bucket)
   );

   assign req_ready = !q_full;
   assign q_push = req_valid && req_ready;
   assign q_push_data = {front_item, front_bucket};
   assign q_item = q_pop_data[ENTRY_WIDTH-1:BUCKET_WIDTH];
   assign q_bucket = q_pop_data[BUCKET_WIDTH-1:0];

   cfrf_queue #(
      .WIDTH (ENTRY_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   cfrf_back #(
      .USED_BUCKETS (USED_BUCKETS),
      .BUCKET_WIDTH (BUCKET_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_item       (q_item),
      .q_bucket     (q_bucket),
      .q_pop        (q_pop),
      .med_interval (med_interval_ff),
      .low_interval (low_interval_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_beat     (rsp_data)
   );

endmodule

FILE: hdl/cfrf_front.sv
// front end: classifies a frame identifier and maps it to its bucket
module cfrf_front #(
   parameter int unsigned LOW_BUCKETS = 256,
   parameter int unsigned BUCKET_WIDTH = 8
) (
   input  cfrf_pkg::req_beat_type  req_beat,
   output cfrf_pkg::work_item_type item,
   output logic [BUCKET_WIDTH-1:0] bucket
);

   logic [BUCKET_WIDTH-1:0] bucket_map [cfrf_pkg::BYTE_VALUES];
   logic [cfrf_pkg::ID_WIDTH-1:0] med_offset;

   for (genvar g = 0; g < cfrf_pkg::BYTE_VALUES; g++) begin : g_map
      assign bucket_map[g] = BUCKET_WIDTH'(g % LOW_BUCKETS);
   end

   assign bucket = bucket_map[req_beat.can_id[7:0]];
   assign med_offset = req_beat.can_id - cfrf_pkg::MED_ID_FIRST;

   always_comb begin
      item.now_ms = req_beat.now_ms;
      item.med_slot = med_offset[cfrf_pkg::MED_SLOT_WIDTH-1:0];
      if (req_beat.can_id >= cfrf_pkg::CRIT_ID_FIRST &&
          req_beat.can_id <= cfrf_pkg::CRIT_ID_LAST) begin
         item.prio = cfrf_pkg::PRIO_CRITICAL;
      end else if (req_beat.can_id >= cfrf_pkg::MED_ID_FIRST &&
                   req_beat.can_id <= cfrf_pkg::MED_ID_LAST) begin
         item.prio = cfrf_pkg::PRIO_MEDIUM;
      end else begin
         item.prio = cfrf_pkg::PRIO_LOW;
      end
   end

endmodule

FILE: hdl/cfrf_queue.sv
// two-entry queue between the front end and the back end
module cfrf_queue #(
   parameter int unsigned WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [cfrf_pkg::QUEUE_DEPTH];
   logic [cfrf_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cfrf_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cfrf_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   assign full = (count_ff == cfrf_pkg::QUEUE_CNT_WIDTH'(cfrf_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/cfrf_back.sv
// back end: last-pass stores, elapsed time check and result register
module cfrf_back #(
   parameter int unsigned USED_BUCKETS = 256,
   parameter int unsigned BUCKET_WIDTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  cfrf_pkg::work_item_type             q_item,
   input  logic [BUCKET_WIDTH-1:0]             q_bucket,
   output logic                                q_pop,
   input  logic [cfrf_pkg::TIME_WIDTH-1:0]     med_interval,
   input  logic [cfrf_pkg::TIME_WIDTH-1:0]     low_interval,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cfrf_pkg::rsp_beat_type              rsp_beat
);

   logic [cfrf_pkg::TIME_WIDTH-1:0] low_last_mem [USED_BUCKETS];
   logic [USED_BUCKETS-1:0] low_seen_ff;
   logic [cfrf_pkg::TIME_WIDTH-1:0] med_last_ff [cfrf_pkg::MED_SLOTS];

   logic s1_valid_ff, s1_valid_in;
   cfrf_pkg::work_item_type s1_item_ff;
   logic [BUCKET_WIDTH-1:0] s1_bucket_ff;
   logic [cfrf_pkg::TIME_WIDTH-1:0] rd_data_ff;
   logic byp_hit_ff, byp_hit_in;
   logic [cfrf_pkg::TIME_WIDTH-1:0] byp_data_ff;
   logic out_valid_ff, out_valid_in;
   cfrf_pkg::rsp_beat_type out_beat_ff, out_beat_in;

   logic out_free, s1_adv;
   logic [cfrf_pkg::TIME_WIDTH-1:0] last_low, last_med, last, gap, elapsed;
   logic gap_ok, pass, low_wr, med_wr;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s1_adv = s1_valid_ff && out_free;
   assign q_pop = !q_empty && (!s1_valid_ff || out_free);

   always_comb begin
      if (byp_hit_ff) begin
         last_low = byp_data_ff;
      end else if (low_seen_ff[s1_bucket_ff]) begin
         last_low = rd_data_ff;
      end else begin
         last_low = '0;
      end
      last_med = med_last_ff[s1_item_ff.med_slot];
      if (s1_item_ff.prio == cfrf_pkg::PRIO_MEDIUM) begin
         last = last_med;
         gap = med_interval;
      end else begin
         last = last_low;
         gap = low_interval;
      end
      elapsed = s1_item_ff.now_ms - last;
      gap_ok = elapsed > gap;
      pass = (s1_item_ff.prio == cfrf_pkg::PRIO_CRITICAL) || gap_ok;
      low_wr = s1_adv && (s1_item_ff.prio == cfrf_pkg::PRIO_LOW) && gap_ok;
      med_wr = s1_adv && (s1_item_ff.prio == cfrf_pkg::PRIO_MEDIUM) && gap_ok;
      byp_hit_in = low_wr && (s1_bucket_ff == q_bucket);
      s1_valid_in = q_pop || (s1_valid_ff && !s1_adv);
      out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);
      out_beat_in.pass_frame = pass;
      out_beat_in.priority_class = s1_item_ff.prio;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         byp_hit_ff <= 1'b0;
         low_seen_ff <= '0;
         for (int i = 0; i < cfrf_pkg::MED_SLOTS; i++) begin
            med_last_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            byp_hit_ff <= byp_hit_in;
         end
         if (low_wr) begin
            low_seen_ff[s1_bucket_ff] <= 1'b1;
         end
         if (med_wr) begin
            med_last_ff[s1_item_ff.med_slot] <= s1_item_ff.now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_item_ff <= q_item;
         s1_bucket_ff <= q_bucket;
         byp_data_ff <= s1_item_ff.now_ms;
      end
      if (s1_adv) begin
         out_beat_ff <= out_beat_in;
      end
   end

   // low-priority last-pass store, read-before-write
   always_ff @(posedge clock) begin
      if (low_wr) begin
         low_last_mem[s1_bucket_ff] <= s1_item_ff.now_ms;
      end
      if (q_pop) begin
         rd_data_ff <= low_last_mem[q_bucket];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat = out_beat_ff;

endmodule
